// File: hdl/zbf_pkg.sv
// Shared types and constants for the flat polygon fill block.
// Used by the controller, datapath, divider and top level; no dependencies.
package zbf_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DS_AW        = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DIV_W        = 33;

  localparam logic [31:0] DEPTH_MAX = 32'h7FFF_FFFF;
  localparam logic [23:0] X_ROUND   = 24'h00_8000;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         vertex_x;
    logic [7:0]         vertex_y;
    logic signed [31:0] vertex_z;
    logic               vertex_last;
    logic [15:0]        fill_color;
  } in_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        done_res;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_CL_INIT, S_E_RD, S_E_SET, S_E_DX, S_E_DZ, S_E_WALK,
    S_E_NEXT, S_CL_END, S_SK_RD, S_SK_CHK, S_SK_DIV, S_TK_RD, S_TK_CMP, S_OUT
  } state_t;

  typedef struct packed {
    logic vtx_wr;
    logic tk_idle;
    logic clr_start;
    logic clr_step;
    logic cl_init;
    logic e_set;
    logic e_kx;
    logic e_kz;
    logic e_walk;
    logic e_next;
    logic cl_end;
    logic sk_chk;
    logic sk_step;
    logic tk_rd;
    logic tk_cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic edge_flat;
    logic edge_last;
    logic walk_end;
    logic div_done;
    logic poly_flat;
    logic row_empty;
    logic seek_last;
    logic col_end;
    logic row_last;
    logic clr_end;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/zbuffer_flat_polygon_fill.sv
// Top level of the flat polygon fill block with depth buffer.
// Depends on zbf_pkg, zbf_ctrl, zbf_datapath (which holds zbf_div).
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one transaction per command.
//    func LOAD stores a vertex; with vertex_last set it also takes the
//    colour and sets up the edge tables. TICK visits the next span pixel
//    and returns one result transaction. CLEAR fills the depth store with
//    the maximum depth. Code 3 is taken and dropped.
//  - Output channel (out_valid/out_ready/out_data): one transaction per
//    TICK; pixel_valid marks a depth-test pass, done_res that the fill is
//    over. A finished result sits in an output register, so the next
//    command is taken while the receiver stalls; a later tick waits there.
//  - cfg_we/cfg_index/cfg_data write screen_width (0) and screen_height (1);
//    the user must do so only while the block is idle; it is not enforced.
//  - A TICK reads the depth store and compares while the pixel stays in its
//    row; at a row end it also skips empty rows and runs the span slope
//    divide (one-bit-per-cycle divider). Closing a polygon costs per edge
//    two divides plus one walk step a row.
//    CLEAR writes one depth word a cycle over width*height words.
//  - Reset: registers return to 256x256, no fill active, vertex count zero.
//    Depth store contents are undefined until the first CLEAR.
module zbuffer_flat_polygon_fill import zbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  zbf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .func        (in_data.func),
    .vertex_last (in_data.vertex_last),
    .stat        (stat),
    .in_ready    (in_ready),
    .cmd         (cmd)
  );

  // stores, arithmetic and the result register
  zbf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/zbf_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on zbf_pkg.
module zbf_div import zbf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DIV_W-1:0] num,
  input  logic [7:0]              den,
  output logic signed [DIV_W-1:0] quo,
  output logic                    done
);

  logic [DIV_W-1:0] mag;
  logic [7:0]       rem;
  logic [7:0]       dvs;
  logic             neg;
  logic             busy;
  logic [5:0]       cnt;
  logic [8:0]       trial;
  logic             qbit;

  assign trial = {rem, mag[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});
  assign quo   = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvs  <= den;
        neg  <= num[DIV_W-1];
        mag  <= num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
      end else if (busy) begin
        rem <= qbit ? 8'(trial - {1'b0, dvs}) : trial[7:0];
        mag <= {mag[DIV_W-2:0], qbit};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/zbf_datapath.sv
// Datapath: vertex store, edge tables, depth store, scan registers, result register.
// Depends on zbf_pkg and zbf_div; driven by zbf_ctrl commands.
module zbf_datapath import zbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  in_t        in_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  input  cmd_t       cmd,
  output stat_t      stat,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data
);

  typedef struct packed {
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] z;
  } vtx_t;

  typedef struct packed {
    logic [7:0]  x;
    logic [31:0] z;
  } edge_t;

  // configuration
  logic [8:0] w_reg, h_reg, w_eff, h_eff;

  // vertices
  vtx_t             vmem [MAX_VERTICES];
  vtx_t             va, vb, lo, hi;
  logic [CNT_W-1:0] vcount, n_reg;
  logic [VIDX_W-1:0] ei, ej;
  logic [7:0]       ymin, ymax;

  // edge walk
  logic        side_r, e_side;
  logic [7:0]  x_low, y_cur, y_high, dy;
  logic [31:0] z_low, z_high;
  logic [23:0] kx, x_acc, xn, xr;
  logic [31:0] kz, z_acc, zn;

  // edge tables
  edge_t       lmem [256];
  edge_t       rmem [256];
  edge_t       lq, rq, tw_data;
  logic        tw_en, tw_side;
  logic [7:0]  tw_addr;

  // scan
  logic [7:0]  seek_y, last_row, scan_row, scan_col, end_col, col_n, span_n;
  logic [31:0] scan_depth, scan_step;
  logic        active;
  logic [15:0] color;

  // depth store
  logic [31:0]      ds [2**DS_AW];
  logic [31:0]      ds_q;
  logic [DS_AW-1:0] ds_addr, ds_addr_n;
  logic [16:0]      row_base, clr_total, clr_cnt;
  logic             closer;

  // divider
  logic                    div_start, div_done;
  logic signed [DIV_W-1:0] div_num, div_quo;
  logic [7:0]              div_den;
  logic signed [8:0]       dx;

  out_t res;

  assign w_eff = (w_reg == 9'd0) ? 9'd1 : (w_reg > 9'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : w_reg;
  assign h_eff = (h_reg == 9'd0) ? 9'd1 : (h_reg > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : h_reg;

  assign ej     = (CNT_W'(ei) == n_reg - CNT_W'(1)) ? '0 : ei + VIDX_W'(1);
  assign side_r = va.y > vb.y;
  assign lo     = side_r ? vb : va;
  assign hi     = side_r ? va : vb;
  assign dx     = $signed({1'b0, hi.x}) - $signed({1'b0, lo.x});

  assign xn = x_acc + kx;
  assign xr = xn + X_ROUND;
  assign zn = z_acc + kz;

  assign tw_en   = (cmd.e_set && !stat.edge_flat) || cmd.e_walk;
  assign tw_side = cmd.e_set ? side_r : e_side;
  assign tw_addr = cmd.e_set ? lo.y : y_cur + 8'd1;
  assign tw_data = cmd.e_set ? edge_t'{x: lo.x, z: lo.z} : edge_t'{x: xr[23:16], z: zn};

  assign span_n = (lq.x > rq.x) ? lq.x - rq.x : rq.x - lq.x;
  assign col_n  = (end_col > scan_col) ? scan_col + 8'd1 : scan_col - 8'd1;

  assign row_base  = 17'(scan_row) * 17'(w_eff);
  assign ds_addr_n = DS_AW'(row_base + 17'(col_n));
  assign clr_total = 17'(w_eff) * 17'(h_eff);
  assign closer    = $signed(scan_depth) < $signed(ds_q);

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = dy;
    if (cmd.e_set) begin
      div_start = !stat.edge_flat;
      div_num   = {{8{dx[8]}}, dx, 16'h0000};
      div_den   = hi.y - lo.y;
    end else if (cmd.e_kx) begin
      div_start = 1'b1;
      div_num   = $signed({z_high[31], z_high}) - $signed({z_low[31], z_low});
    end else if (cmd.sk_chk) begin
      div_start = !stat.row_empty;
      div_num   = $signed({rq.z[31], rq.z}) - $signed({lq.z[31], lq.z});
      div_den   = span_n;
    end
  end

  zbf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      w_reg <= 9'(MAX_WIDTH);
      h_reg <= 9'(MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SCREEN_WIDTH:  w_reg <= cfg_data;
        REG_SCREEN_HEIGHT: h_reg <= cfg_data;
      endcase
    end
  end

  // vertex store, read ports always pointing at the current edge
  always_ff @(posedge clk) begin
    if (cmd.vtx_wr && vcount < CNT_W'(MAX_VERTICES)) begin
      vmem[vcount[VIDX_W-1:0]] <= vtx_t'{x: in_data.vertex_x, y: in_data.vertex_y,
                                         z: in_data.vertex_z};
    end
    va <= vmem[ei];
    vb <= vmem[ej];
  end

  // edge tables, read at the seek row every cycle
  always_ff @(posedge clk) begin
    if (tw_en && !tw_side) lmem[tw_addr] <= tw_data;
    if (tw_en && tw_side)  rmem[tw_addr] <= tw_data;
    lq <= lmem[seek_y];
    rq <= rmem[seek_y];
  end

  // depth store, single write port shared by clear and depth update
  always_ff @(posedge clk) begin
    if (cmd.clr_step || (cmd.tk_cmp && closer))
      ds[cmd.clr_step ? clr_cnt[DS_AW-1:0] : ds_addr] <= cmd.clr_step ? DEPTH_MAX : scan_depth;
    if (cmd.tk_rd) ds_q <= ds[ds_addr_n];
  end

  // control-bearing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
      active <= 1'b0;
      color  <= '0;
    end else begin
      if (cmd.vtx_wr) begin
        if (vcount < CNT_W'(MAX_VERTICES)) vcount <= vcount + CNT_W'(1);
        if (in_data.vertex_last) color <= in_data.fill_color;
      end
      if (cmd.cl_init) vcount <= '0;
      if (cmd.cl_end && stat.poly_flat) active <= 1'b0;
      if (cmd.sk_chk && stat.row_empty && stat.seek_last) active <= 1'b0;
      if (cmd.sk_step) active <= 1'b1;
      if (cmd.tk_cmp && stat.col_end && stat.row_last) active <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cl_init) begin
      n_reg <= vcount;
      ei    <= '0;
      ymin  <= 8'hFF;
      ymax  <= 8'h00;
    end
    if (cmd.e_set) begin
      if (va.y < ymin) ymin <= va.y;
      if (va.y > ymax) ymax <= va.y;
      e_side <= side_r;
      x_low  <= lo.x;
      z_low  <= lo.z;
      z_high <= hi.z;
      y_cur  <= lo.y;
      y_high <= hi.y;
      dy     <= hi.y - lo.y;
    end
    if (cmd.e_kx) kx <= div_quo[23:0];
    if (cmd.e_kz) begin
      kz    <= div_quo[31:0];
      x_acc <= {x_low, 16'h0000};
      z_acc <= z_low;
    end
    if (cmd.e_walk) begin
      x_acc <= xn;
      z_acc <= zn;
      y_cur <= y_cur + 8'd1;
    end
    if (cmd.e_next) ei <= ei + VIDX_W'(1);
    if (cmd.cl_end) begin
      last_row <= ymax;
      seek_y   <= ymin;
    end
    if (cmd.sk_chk) begin
      scan_col   <= lq.x;
      scan_depth <= lq.z;
      end_col    <= rq.x;
      scan_row   <= seek_y;
      if (stat.row_empty) seek_y <= seek_y + 8'd1;
    end
    if (cmd.sk_step) scan_step <= div_quo[31:0];
    if (cmd.clr_start) clr_cnt <= '0;
    if (cmd.clr_step)  clr_cnt <= clr_cnt + 17'd1;
    if (cmd.tk_idle || cmd.tk_rd) res <= '0;
    if (cmd.tk_rd) begin
      scan_col   <= col_n;
      scan_depth <= scan_depth + scan_step;
      ds_addr    <= ds_addr_n;
    end
    if (cmd.tk_cmp) begin
      if (closer) res <= out_t'{pixel_valid: 1'b1, pixel_x: scan_col, pixel_y: scan_row,
                                pixel_color: color, done_res: 1'b0};
      if (stat.col_end && !stat.row_last) seek_y <= scan_row + 8'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= out_t'{pixel_valid: res.pixel_valid, pixel_x: res.pixel_x,
                         pixel_y: res.pixel_y, pixel_color: res.pixel_color,
                         done_res: !active};
    end
  end

  assign stat.active    = active;
  assign stat.edge_flat = (va.y == vb.y);
  assign stat.edge_last = (CNT_W'(ei) == n_reg - CNT_W'(1));
  assign stat.walk_end  = (y_cur + 8'd1 == y_high);
  assign stat.div_done  = div_done;
  assign stat.poly_flat = (ymin == ymax);
  assign stat.row_empty = (lq.x == rq.x);
  assign stat.seek_last = (seek_y == last_row);
  assign stat.col_end   = (scan_col == end_col);
  assign stat.row_last  = (scan_row >= last_row);
  assign stat.clr_end   = (clr_cnt == clr_total - 17'd1);
  assign stat.out_free  = !out_valid || out_ready;

`ifndef NO_ASSERTIONS
  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.tk_cmp |-> $past(cmd.tk_rd))
    else $error("depth compare without a preceding store read");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.e_walk |-> (y_cur != y_high))
    else $error("edge walk ran past its end row");
  a_step_on_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.sk_step || cmd.e_kx || cmd.e_kz) |-> div_done)
    else $error("quotient taken before divider finished");
`endif

endmodule

// File: hdl/zbf_ctrl.sv
// Controller state machine: sequences load, edge setup, row seek, tick and clear.
// Depends on zbf_pkg; talks to zbf_datapath through cmd_t and stat_t.
module zbf_ctrl import zbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] func,
  input  logic       vertex_last,
  input  stat_t      stat,
  output logic       in_ready,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   sk_tick;
  logic   seek_done;

  // seek finishes when a row is found or the last row is empty
  assign seek_done = (state == S_SK_DIV && stat.div_done) ||
                     (state == S_SK_CHK && stat.row_empty && stat.seek_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sk_tick <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.cl_end) sk_tick <= 1'b0;
      else if (cmd.tk_cmp) sk_tick <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (func_t'(func))
            FUNC_LOAD:  if (vertex_last) state_next = S_CL_INIT;
            FUNC_TICK:  state_next = stat.active ? S_TK_RD : S_OUT;
            FUNC_CLEAR: state_next = S_CLEAR;
            FUNC_NONE:  state_next = S_IDLE;
          endcase
        end
      end
      S_CLEAR:   if (stat.clr_end) state_next = S_IDLE;
      S_CL_INIT: state_next = S_E_RD;
      S_E_RD:    state_next = S_E_SET;
      S_E_SET:   state_next = stat.edge_flat ? S_E_NEXT : S_E_DX;
      S_E_DX:    if (stat.div_done) state_next = S_E_DZ;
      S_E_DZ:    if (stat.div_done) state_next = S_E_WALK;
      S_E_WALK:  if (stat.walk_end) state_next = S_E_NEXT;
      S_E_NEXT:  state_next = stat.edge_last ? S_CL_END : S_E_RD;
      S_CL_END:  state_next = stat.poly_flat ? S_IDLE : S_SK_RD;
      S_SK_RD:   state_next = S_SK_CHK;
      S_SK_CHK: begin
        if (!stat.row_empty) state_next = S_SK_DIV;
        else if (!stat.seek_last) state_next = S_SK_RD;
      end
      S_SK_DIV:  ;
      S_TK_RD:   state_next = S_TK_CMP;
      S_TK_CMP: begin
        if (stat.col_end && !stat.row_last) state_next = S_SK_RD;
        else state_next = S_OUT;
      end
      S_OUT:     if (stat.out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
    if (seek_done) state_next = sk_tick ? S_OUT : S_IDLE;
  end

  always_comb begin
    cmd      = '0;
    in_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (func_t'(func))
            FUNC_LOAD:  cmd.vtx_wr = 1'b1;
            FUNC_TICK:  cmd.tk_idle = !stat.active;
            FUNC_CLEAR: cmd.clr_start = 1'b1;
            FUNC_NONE:  ;
          endcase
        end
      end
      S_CLEAR:   cmd.clr_step = 1'b1;
      S_CL_INIT: cmd.cl_init = 1'b1;
      S_E_RD:    ;
      S_E_SET:   cmd.e_set = 1'b1;
      S_E_DX:    cmd.e_kx = stat.div_done;
      S_E_DZ:    cmd.e_kz = stat.div_done;
      S_E_WALK:  cmd.e_walk = 1'b1;
      S_E_NEXT:  cmd.e_next = !stat.edge_last;
      S_CL_END:  cmd.cl_end = 1'b1;
      S_SK_RD:   ;
      S_SK_CHK:  cmd.sk_chk = 1'b1;
      S_SK_DIV:  cmd.sk_step = stat.div_done;
      S_TK_RD:   cmd.tk_rd = 1'b1;
      S_TK_CMP:  cmd.tk_cmp = 1'b1;
      S_OUT:     cmd.out_load = stat.out_free;
      default:   ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_ready_idle_only: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_TK_CMP))
    else $error("tick compare entered straight from accept");
  a_tick_flag: assert property (@(posedge clk) disable iff (rst)
    (state == S_TK_CMP) |=> sk_tick)
    else $error("seek after tick not flagged for delivery");
  a_out_after_tick: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (sk_tick || $past(cmd.tk_idle) || $past(state == S_OUT)))
    else $error("result delivered without a tick");
`endif

endmodule
